### rtl/adc_os_pkg.sv
// Package for the ADC oversampling averager: frame geometry, derived widths,
// register indexes and register reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adc_os_pkg;

  // Frame geometry; OVERSAMPLE is taken as a power of two (1, 2, 4, 8, 16).
  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned OVERSAMPLE = 8;

  localparam int unsigned SampleW = 12;
  localparam int unsigned AvgW    = 15;
  localparam int unsigned VoltW   = 16;
  localparam int unsigned OffW    = 15;
  localparam int unsigned GainW   = 16;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned ChOutW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam int unsigned AccW    = $clog2(4095 * OVERSAMPLE + 1);
  localparam int unsigned OsLog2  = $clog2(OVERSAMPLE);
  localparam int unsigned ChW     = $clog2(CHANNELS);
  localparam int unsigned RndW    = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int unsigned AddrW   = ChW + 1;
  localparam int unsigned MemDepth = 2 ** AddrW;
  localparam int unsigned GainFracBits = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOffsetAnalog  = 3'd0,
    CfgOffsetEncoder = 3'd1,
    CfgGainAnalog    = 3'd2,
    CfgGainEncoder   = 3'd3,
    CfgEncoderMask   = 3'd4
  } cfg_idx_e;

  localparam logic [OffW-1:0]  OffsetAnalogRst  = 15'd16384;
  localparam logic [OffW-1:0]  OffsetEncoderRst = 15'd16384;
  localparam logic [GainW-1:0] GainAnalogRst    = 16'(144250 / 8);
  localparam logic [GainW-1:0] GainEncoderRst   = 16'(11996 / 8);
  localparam logic [MaskW-1:0] EncoderMaskRst   = 8'd12;

endpackage

`default_nettype wire

### rtl/adc_oversample_average_scale_core.sv
// Top level of the ADC oversampling averager with offset and gain scaling.
// Depends on adc_os_pkg for geometry, widths and register indexes.
//
// One sample is taken per clock cycle in channel-interleaved order. Sums live
// in a two-bank memory (one bank per frame in flight) with a registered read;
// each sample is a read-modify-write with registered write data, and the first
// round of a frame overwrites instead of adding, so no clearing pass exists.
// Once a frame is complete its bank is read back one channel per cycle while
// the output is not stalled, through a three-stage scaling pipeline (read,
// multiply, round and saturate), so results leave at one per cycle.
// Input stalls only at the start of a frame whose bank still holds results
// not yet read out, which happens only under output backpressure.
`timescale 1ns / 1ps
`default_nettype none

module adc_oversample_average_scale_core
  import adc_os_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [CfgW-1:0]          cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [SampleW-1:0]       sample_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ChOutW-1:0]             channel_index_o,
  output logic [AvgW-1:0]               average_o,
  output logic signed [VoltW-1:0]       voltage_o,
  output logic                          last_o
);

  logic [OffW-1:0]  off_ana_q, off_enc_q;
  logic [GainW-1:0] gain_ana_q, gain_enc_q;
  logic [MaskW-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_ana_q  <= OffsetAnalogRst;
      off_enc_q  <= OffsetEncoderRst;
      gain_ana_q <= GainAnalogRst;
      gain_enc_q <= GainEncoderRst;
      mask_q     <= EncoderMaskRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOffsetAnalog:  off_ana_q  <= cfg_data_i[OffW-1:0];
        CfgOffsetEncoder: off_enc_q  <= cfg_data_i[OffW-1:0];
        CfgGainAnalog:    gain_ana_q <= cfg_data_i[GainW-1:0];
        CfgGainEncoder:   gain_enc_q <= cfg_data_i[GainW-1:0];
        CfgEncoderMask:   mask_q     <= cfg_data_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // Accumulation side
  logic [ChW-1:0]   ch_q;
  logic [RndW-1:0]  rnd_q;
  logic             bank_q;
  logic [1:0]       pend_q;
  logic             in_acc;
  logic             frame_end;

  logic             wr_valid_q;
  logic [AddrW-1:0] wr_addr_q;
  logic [SampleW-1:0] samp_q;
  logic             wr_first_q;
  logic             wr_last_q;
  logic [AccW-1:0]  rda_q;

  logic [AccW-1:0]  mem [MemDepth];

  assign in_ready_o = !(ch_q == '0 && rnd_q == '0 && pend_q[bank_q]);
  assign in_acc     = in_valid_i && in_ready_o;
  assign frame_end  = (ch_q == ChW'(CHANNELS - 1)) && (rnd_q == RndW'(OVERSAMPLE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q       <= '0;
      rnd_q      <= '0;
      bank_q     <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= in_acc;
      if (in_acc) begin
        if (ch_q == ChW'(CHANNELS - 1)) begin
          ch_q <= '0;
          if (rnd_q == RndW'(OVERSAMPLE - 1)) begin
            rnd_q  <= '0;
            bank_q <= !bank_q;
          end else begin
            rnd_q <= rnd_q + RndW'(1);
          end
        end else begin
          ch_q <= ch_q + ChW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_addr_q  <= {bank_q, ch_q};
      samp_q     <= sample_i;
      wr_first_q <= (rnd_q == '0);
      wr_last_q  <= frame_end;
    end
  end

  // Emission side
  logic             en;
  logic             iss;
  logic             em_bank_q;
  logic [ChW-1:0]   em_ch_q;
  logic             em_done;

  logic             v1_q, last1_q;
  logic [ChW-1:0]   ch1_q;
  logic [AccW-1:0]  rdb_q;

  assign en      = !out_valid_o || out_ready_i;
  assign iss     = en && pend_q[em_bank_q];
  assign em_done = iss && (em_ch_q == ChW'(CHANNELS - 1));

  always_ff @(posedge clk_i) begin
    if (wr_valid_q) begin
      mem[wr_addr_q] <= wr_first_q ? AccW'(samp_q) : rda_q + AccW'(samp_q);
    end
    if (in_acc) begin
      rda_q <= mem[{bank_q, ch_q}];
    end
    if (iss) begin
      rdb_q <= mem[{em_bank_q, em_ch_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      em_bank_q <= 1'b0;
      em_ch_q   <= '0;
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (wr_valid_q && wr_last_q && (wr_addr_q[ChW] == 1'(b))) begin
          pend_q[b] <= 1'b1;
        end else if (em_done && (em_bank_q == 1'(b))) begin
          pend_q[b] <= 1'b0;
        end
      end
      if (iss) begin
        if (em_done) begin
          em_ch_q   <= '0;
          em_bank_q <= !em_bank_q;
        end else begin
          em_ch_q <= em_ch_q + ChW'(1);
        end
      end
    end
  end

  // Stage 1: scale the sum, pick offset and gain, form the product
  logic [AccW+2:0]       scaled;
  logic [AvgW-1:0]       avg1;
  logic [ChOutW-1:0]     ch1x;
  logic                  enc1;
  logic [OffW-1:0]       off1;
  logic [GainW-1:0]      gain1;
  logic signed [AvgW:0]  diff1;
  logic signed [32:0]    prod_full;

  assign scaled    = {rdb_q, 3'b000} >> OsLog2;
  assign avg1      = scaled[AvgW-1:0];
  assign ch1x      = ChOutW'(ch1_q);
  assign enc1      = mask_q[ch1x];
  assign off1      = enc1 ? off_enc_q : off_ana_q;
  assign gain1     = enc1 ? gain_enc_q : gain_ana_q;
  assign diff1     = $signed({1'b0, avg1}) - $signed({1'b0, off1});
  assign prod_full = diff1 * $signed({1'b0, gain1});

  logic                 v2_q, last2_q;
  logic [ChW-1:0]       ch2_q;
  logic [AvgW-1:0]      avg2_q;
  logic signed [31:0]   prod_q;

  // Stage 2: truncate toward zero and saturate
  logic signed [31:0]   biased;
  logic signed [17:0]   quot;
  logic signed [VoltW-1:0] volt2;

  assign biased = prod_q + (prod_q[31] ? 32'sd16383 : 32'sd0);
  assign quot   = biased[31:GainFracBits];

  always_comb begin
    if (quot > 18'sd32767) begin
      volt2 = 16'sh7FFF;
    end else if (quot < -18'sd32768) begin
      volt2 = 16'sh8000;
    end else begin
      volt2 = quot[VoltW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q        <= iss;
      v2_q        <= v1_q;
      out_valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch1_q           <= em_ch_q;
      last1_q         <= (em_ch_q == ChW'(CHANNELS - 1));
      ch2_q           <= ch1_q;
      last2_q         <= last1_q;
      avg2_q          <= avg1;
      prod_q          <= prod_full[31:0];
      channel_index_o <= ChOutW'(ch2_q);
      average_o       <= avg2_q;
      voltage_o       <= volt2;
      last_o          <= last2_q;
    end
  end

  // Checks
  ap_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_q && iss |-> wr_addr_q[ChW] != em_bank_q)
    else $error("accumulate write hits the bank being read out");

  ap_last_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> channel_index_o == ChOutW'(CHANNELS - 1))
    else $error("frame end flagged on a channel other than the last");

  ap_pend_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_q && wr_last_q |=> pend_q[$past(wr_addr_q[ChW])])
    else $error("completed frame not marked for readout");

endmodule

`default_nettype wire
